// ----- rtl/pstu_pkg.sv -----
// ----------------------------------------------------------------------------
// pstu_pkg
// Types and constants shared by the sample-to-unorm converter modules.
// ----------------------------------------------------------------------------
package pstu_pkg;

  localparam int QueueDepth = 4;

  // source formats
  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_U16 = 2'd1;
  localparam logic [1:0] FMT_F32 = 2'd2;
  localparam logic [1:0] FMT_F16 = 2'd3;

  // register select, taken from paddr[2]
  localparam logic REG_SRC_FMT  = 1'b0;
  localparam logic REG_OUT_MODE = 1'b1;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_DIV,
    KIND_FLT
  } kind_t;

  // mant carries the result (pass), the integer sample (div) or the
  // significand with hidden one (float)
  typedef struct packed {
    kind_t       kind;
    logic        wide;
    logic [23:0] mant;
    logic [7:0]  expo;
  } item_t;

endpackage

// ----- rtl/pstu_front.sv -----
// ----------------------------------------------------------------------------
// pstu_front
// Accepts samples, widens half floats and sorts each sample into a pass,
// integer-divide or float-quantize job for the back end.
// ----------------------------------------------------------------------------
module pstu_front import pstu_pkg::*; (
  input  logic [1:0]  src_fmt,
  input  logic        out_mode,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        q_full,
  output logic        push,
  output item_t       item
);

  logic        sgn;
  logic [7:0]  e;
  logic [22:0] f;
  logic [3:0]  j;
  logic [4:0]  hex;
  logic [9:0]  hman;
  logic [9:0]  nman;
  logic [15:0] full_scale;

  always_comb begin
    hex  = s_tdata[14:10];
    hman = s_tdata[9:0];
    j = '0;
    for (int i = 0; i < 10; i++) begin
      if (hman[i]) begin
        j = 4'(i);
      end
    end
    // shift the leading one out of the field
    nman = 10'(hman << (4'd10 - j));

    if (src_fmt == FMT_F16) begin
      sgn = s_tdata[15];
      if (hex == 5'd0) begin
        if (hman != 10'd0) begin
          e = 8'd103 + {4'b0, j};
          f = {nman, 13'b0};
        end else begin
          e = 8'd0;
          f = '0;
        end
      end else if (hex == 5'd31) begin
        e = 8'd255;
        f = {hman, 13'b0};
      end else begin
        e = {3'b0, hex} + 8'd112;
        f = {hman, 13'b0};
      end
    end else begin
      sgn = s_tdata[31];
      e   = s_tdata[30:23];
      f   = s_tdata[22:0];
    end

    full_scale = out_mode ? 16'hffff : 16'h00ff;

    item.wide = out_mode;
    item.expo = e;
    item.kind = KIND_FLT;
    item.mant = {1'b1, f};
    if (!out_mode && src_fmt == FMT_U8) begin
      item.kind = KIND_PASS;
      item.mant = {16'b0, s_tdata[7:0]};
    end else if (out_mode && src_fmt == FMT_U16) begin
      item.kind = KIND_PASS;
      item.mant = {8'b0, s_tdata[15:0]};
    end else if (src_fmt == FMT_U8) begin
      // x/255 scaled to 16 bits is exactly x*257
      item.kind = KIND_PASS;
      item.mant = {8'b0, s_tdata[7:0], s_tdata[7:0]};
    end else if (src_fmt == FMT_U16) begin
      item.kind = KIND_DIV;
      item.mant = {8'b0, s_tdata[15:0]};
    end else if (e == 8'd255 || sgn || e == 8'd0) begin
      // non-finite, negative, zero or subnormal
      item.kind = KIND_PASS;
      item.mant = '0;
    end else if (e >= 8'd127) begin
      item.kind = KIND_PASS;
      item.mant = {8'b0, full_scale};
    end
  end

  assign s_tready = ~q_full;
  assign push     = s_tvalid & ~q_full;

endmodule

// ----- rtl/pstu_queue.sv -----
// ----------------------------------------------------------------------------
// pstu_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pstu_queue import pstu_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_item,
  output logic  full,
  output logic  nonempty,
  input  logic  pop,
  output item_t rd_item
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  item_t          slots [Depth];
  logic [AW-1:0]  wptr;
  logic [AW-1:0]  rptr;
  logic [CW-1:0]  count;
  logic           do_pop;

  assign full     = (count == CW'(Depth));
  assign nonempty = (count != '0);
  assign do_pop   = pop & nonempty;
  assign rd_item  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/pstu_back.sv -----
// ----------------------------------------------------------------------------
// pstu_back
// Three-stage quantizer (scale, round and align, add half and truncate)
// followed by the byte serializer on the output stream.
// ----------------------------------------------------------------------------
module pstu_back import pstu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_nonempty,
  output logic       q_pop,
  input  item_t      q_item,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tlast
);

  logic        en;
  logic        done;

  logic        s1_valid;
  kind_t       s1_kind;
  logic        s1_wide;
  logic [39:0] s1_x;
  logic [7:0]  s1_expo;

  logic        s2_valid;
  kind_t       s2_kind;
  logic        s2_wide;
  logic [41:0] s2_val;

  logic        s3_valid;
  logic        s3_wide;
  logic [15:0] s3_res;
  logic        phase;

  logic [39:0] x_next;
  logic [41:0] val_next;
  logic [15:0] res_next;

  assign done     = m_tvalid & m_tready & m_tlast;
  assign en       = ~s3_valid | done;
  assign q_pop    = en & q_nonempty;

  // stage 1: scale by 255 / 65535, or multiply by the reciprocal of 257
  always_comb begin
    logic [16:0] y;
    logic [33:0] d;
    logic [23:0] m;
    m = q_item.mant;
    y = 17'(q_item.mant[15:0]) + 17'd128;
    d = {1'b0, y, 16'b0} - {9'b0, y, 8'b0} + {17'b0, y};
    case (q_item.kind)
      KIND_FLT: x_next = q_item.wide ? ({m, 16'b0} - {16'b0, m})
                                     : ({8'b0, m, 8'b0} - {16'b0, m});
      KIND_DIV: x_next = {6'b0, d};
      default:  x_next = {16'b0, q_item.mant};
    endcase
  end

  // stage 2: round the product to 24 bits, place it on a fixed grid
  // with 26 fraction bits
  always_comb begin
    logic              hi;
    logic [39:0]       xn;
    logic [39:0]       yv;
    logic [23:0]       keep;
    logic              g;
    logic              st;
    logic [24:0]       pr;
    logic [5:0]        lsel;
    logic signed [9:0] t;
    logic [4:0]        nt;
    hi   = s1_wide ? s1_x[39] : s1_x[31];
    xn   = hi ? s1_x : {s1_x[38:0], 1'b0};
    yv   = s1_wide ? xn : {xn[31:0], 8'b0};
    keep = yv[39:16];
    g    = yv[15];
    st   = |yv[14:0];
    pr   = {1'b0, keep} + 25'(g & (st | keep[0]));
    lsel = s1_wide ? (hi ? 6'd39 : 6'd38) : (hi ? 6'd31 : 6'd30);
    t    = $signed({4'b0, lsel}) + $signed({2'b0, s1_expo}) - 10'sd147;
    nt   = 5'(-t);
    case (s1_kind)
      KIND_FLT: begin
        if (t >= 10'sd0) begin
          val_next = {17'b0, pr} << t[4:0];
        end else if (t >= -10'sd25) begin
          val_next = {17'b0, pr >> nt};
        end else begin
          val_next = '0;
        end
      end
      KIND_DIV: val_next = {34'b0, s1_x[31:24]};
      default:  val_next = {26'b0, s1_x[15:0]};
    endcase
  end

  // stage 3: add one half, round to single and drop the fraction
  always_comb begin
    logic [41:0] tv;
    logic [15:0] tint;
    logic [25:0] fr;
    logic [3:0]  j;
    logic [4:0]  lowc;
    logic [25:0] mask;
    logic        up;
    tv   = s2_val + (42'd1 << 25);
    tint = tv[41:26];
    fr   = tv[25:0];
    j    = '0;
    for (int i = 0; i < 16; i++) begin
      if (tint[i]) begin
        j = 4'(i);
      end
    end
    lowc = (tint == 16'd0) ? 5'd1 : 5'({1'b0, j} + 5'd2);
    mask = (26'd1 << lowc) - 26'd1;
    up   = &(fr | mask);
    if (s2_kind == KIND_FLT) begin
      res_next = tint + 16'(up);
    end else begin
      res_next = s2_val[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind <= q_item.kind;
      s1_wide <= q_item.wide;
      s1_x    <= x_next;
      s1_expo <= q_item.expo;
      s2_kind <= s1_kind;
      s2_wide <= s1_wide;
      s2_val  <= val_next;
      s3_wide <= s2_wide;
      s3_res  <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      phase    <= 1'b0;
    end else begin
      if (en) begin
        s1_valid <= q_pop;
        s2_valid <= s1_valid;
        s3_valid <= s2_valid;
      end
      if (m_tvalid && m_tready) begin
        phase <= ~m_tlast;
      end
    end
  end

  assign m_tvalid = s3_valid;
  assign m_tdata  = (s3_wide && !phase) ? s3_res[15:8] : s3_res[7:0];
  assign m_tlast  = ~s3_wide | phase;

  a_narrow_fits: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !s3_wide) |-> (s3_res[15:8] == 8'd0))
    else $error("8-bit result exceeds one byte");

  a_phase_wide: assert property (@(posedge clk) disable iff (rst)
    phase |-> (s3_valid && s3_wide))
    else $error("second byte pending outside 16-bit mode");

  a_low_follows: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast))
    else $error("low byte did not follow high byte");

endmodule

// ----- rtl/pixel_sample_to_unorm_bytes_top.sv -----
// ----------------------------------------------------------------------------
// pixel_sample_to_unorm_bytes_top
// Converts raw image samples to 8-bit or 16-bit unsigned-normalized bytes.
// ----------------------------------------------------------------------------
// Samples enter on the s_ stream, one 32-bit sample per beat, and leave on
// the m_ stream as bytes: one byte per sample in 8-bit mode, or the high byte
// then the low byte (tlast on the low one) in 16-bit mode. The input takes
// one sample per cycle while the job queue is not full. Sustained rate is
// one sample per cycle in 8-bit mode while the output is ready; in 16-bit
// mode the quantizer takes a new sample only once both bytes have left,
// as set by the byte-wide output stream. An accepted sample passes through
// the job queue and then the first, second and third quantizer stages,
// the third holding the output beat. Set source_format (address 0) and
// output_width_mode (address 4) only while no sample is in flight.
// ----------------------------------------------------------------------------
module pixel_sample_to_unorm_bytes_top import pstu_pkg::*; #(
  parameter int QDEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample_bits[31:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] src_fmt;
  logic       out_mode;
  logic       push;
  logic       q_full;
  logic       q_nonempty;
  logic       q_pop;
  item_t      wr_item;
  item_t      rd_item;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OUT_MODE) ? {31'b0, out_mode} : {30'b0, src_fmt};

  always_ff @(posedge clk) begin
    if (rst) begin
      src_fmt  <= FMT_U8;
      out_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_SRC_FMT) begin
        src_fmt <= pwdata[1:0];
      end else begin
        out_mode <= pwdata[0];
      end
    end
  end

  pstu_front u_front (
    .src_fmt  (src_fmt),
    .out_mode (out_mode),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .item     (wr_item)
  );

  pstu_queue #(.Depth(QDEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_item  (wr_item),
    .full     (q_full),
    .nonempty (q_nonempty),
    .pop      (q_pop),
    .rd_item  (rd_item)
  );

  pstu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_pop      (q_pop),
    .q_item     (rd_item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sample-to-unorm byte converter.
// ----------------------------------------------------------------------------
// Each sample accepted on the input stream is converted by a bit-exact
// integer model of the single-precision math. The model covers integer
// division, half widening, clamping, scaling and rounding. The expected
// bytes are queued and compared against every beat on the output stream.
// Phases sweep all format and width settings. Both stream sides idle at
// random, except in the final phase.
// ----------------------------------------------------------------------------
module tb;
  import pstu_pkg::*;

  localparam logic [2:0] ADDR_SRC_FMT  = 3'd0;
  localparam logic [2:0] ADDR_OUT_MODE = 3'd4;
  localparam int         HOLD_CYCLES   = 200;

  typedef struct {
    logic [127:0] m;
    int           e;
  } flt_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_beat_t;

  class unorm_scoreboard;
    logic [1:0]  src_fmt;
    logic        wide;
    byte_beat_t  pending_bytes[$];
    int          mismatches;

    function new();
      src_fmt    = FMT_U8;
      wide       = 1'b0;
      mismatches = 0;
    endfunction

    // round to 24 significant bits, nearest even
    function flt_t round_single(logic [127:0] x, int e);
      flt_t         r;
      int           pos;
      int           sh;
      logic [127:0] rem;
      logic [127:0] half;
      pos = -1;
      for (int i = 0; i < 128; i++) if (x[i]) pos = i;
      r.m = x;
      r.e = e;
      if (pos > 23) begin
        sh   = pos - 23;
        r.m  = x >> sh;
        rem  = x & ((128'd1 << sh) - 1);
        half = 128'd1 << (sh - 1);
        if (rem > half || (rem == half && r.m[0])) r.m = r.m + 1;
        r.e = e + sh;
        if (r.m == (128'd1 << 24)) begin
          r.m = r.m >> 1;
          r.e++;
        end
      end
      return r;
    endfunction

    function logic [15:0] to_unorm(flt_t v, logic [127:0] full_scale);
      flt_t         p;
      flt_t         s;
      int           ex;
      logic [127:0] sum;
      if (v.m == 0) return 16'd0;
      p = round_single(v.m * full_scale, v.e);
      if (p.e < -100) return 16'd0;
      ex  = (p.e < -1) ? p.e : -1;
      sum = (p.m << (p.e - ex)) + (128'd1 << (-1 - ex));
      s   = round_single(sum, ex);
      return (s.e >= 0) ? 16'(s.m << s.e) : 16'(s.m >> (-s.e));
    endfunction

    function flt_t sample_value(logic [31:0] raw);
      flt_t         v;
      logic [127:0] n;
      logic [127:0] d;
      logic [127:0] q;
      v.m = 0;
      v.e = 0;
      case (src_fmt)
        FMT_U8, FMT_U16: begin
          n = (src_fmt == FMT_U8) ? 128'(raw[7:0]) : 128'(raw[15:0]);
          d = (src_fmt == FMT_U8) ? 128'd255 : 128'd65535;
          if (n != 0) begin
            q = (n << 60) / d;
            // keep a sticky bit so the rounding sees an inexact quotient
            v = round_single((q << 1) | 128'(((n << 60) % d) != 0), -61);
          end
        end
        FMT_F32: begin
          if (raw[30:23] == 8'hff || raw[31]) begin
          end else if (raw[30:23] > 8'd127 || (raw[30:23] == 8'd127 && raw[22:0] != 0)) begin
            v.m = 1;
          end else if (raw[30:23] == 0) begin
            v.m = 128'(raw[22:0]);
            v.e = -149;
          end else begin
            v.m = 128'({1'b1, raw[22:0]});
            v.e = int'(raw[30:23]) - 150;
          end
        end
        default: begin
          if (raw[14:10] == 5'h1f || raw[15]) begin
          end else if (raw[14:10] > 5'd15 || (raw[14:10] == 5'd15 && raw[9:0] != 0)) begin
            v.m = 1;
          end else if (raw[14:10] == 0) begin
            v.m = 128'(raw[9:0]);
            v.e = -24;
          end else begin
            v.m = 128'({1'b1, raw[9:0]});
            v.e = int'(raw[14:10]) - 25;
          end
        end
      endcase
      return v;
    endfunction

    function void note_sample(logic [31:0] raw);
      logic [15:0] u;
      if (!wide) begin
        u = (src_fmt == FMT_U8) ? 16'(raw[7:0]) : to_unorm(sample_value(raw), 128'd255);
        pending_bytes.push_back('{u[7:0], 1'b1});
      end else begin
        u = (src_fmt == FMT_U16) ? raw[15:0] : to_unorm(sample_value(raw), 128'd65535);
        pending_bytes.push_back('{u[15:8], 1'b0});
        pending_bytes.push_back('{u[7:0], 1'b1});
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      byte_beat_t exp_beat;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat data=%h last=%b", data, last);
        return;
      end
      exp_beat = pending_bytes.pop_front();
      if (exp_beat.data !== data || exp_beat.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected data=%h last=%b, got data=%h last=%b",
                   exp_beat.data, exp_beat.last, data, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  unorm_scoreboard sb = new();
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  always #10 clk = ~clk;

  pixel_sample_to_unorm_bytes_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_byte(m_tdata, m_tlast);
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_sample(logic [31:0] raw);
    s_tvalid <= 1'b1;
    s_tdata  <= raw;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(raw);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic configure(logic [1:0] fmt, logic wide);
    logic [31:0] junk_a;
    logic [31:0] junk_b;
    junk_a = $urandom;
    junk_b = $urandom;
    // upper bits must be dropped by the registers
    reg_write(ADDR_SRC_FMT, {junk_a[31:2], fmt});
    reg_write(ADDR_OUT_MODE, {junk_b[31:1], wide});
    sb.src_fmt = fmt;
    sb.wide    = wide;
  endtask

  function automatic logic [31:0] random_sample(logic [1:0] fmt);
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(0, 9) < 7) begin
      if (fmt == FMT_F32) begin
        r[31]    = 1'b0;
        r[30:23] = 8'($urandom_range(100, 127));
        if (r[30:23] == 8'd127 && $urandom_range(0, 1)) r[22:0] = '0;
      end else if (fmt == FMT_F16) begin
        r[15]    = 1'b0;
        r[14:10] = 5'($urandom_range(0, 15));
      end
    end
    return r;
  endfunction

  localparam logic [31:0] CORNERS[21] = '{
    32'h0000_0000, 32'hffff_ffff, 32'h0000_00ff, 32'h0000_ffff, 32'h3f80_0000,
    32'h3f80_0001, 32'hbf80_0000, 32'h8000_0000, 32'h7f80_0000, 32'h7fc0_0000,
    32'hff80_0000, 32'h0000_0001, 32'h3f00_0000, 32'h0000_3c00, 32'h0000_7c00,
    32'h0000_7e00, 32'h0000_8000, 32'h0000_3800, 32'hdead_3bff, 32'h1234_5680,
    32'h0000_3c01
  };

  initial begin
    logic [1:0] fmt;
    logic       wide;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < 10; ph++) begin
      fmt  = (ph < 8) ? ph[1:0] : 2'($urandom_range(0, 3));
      wide = (ph < 8) ? ph[2] : 1'($urandom_range(0, 1));
      if (ph == 9) calm = 1'b1;
      drain();
      configure(fmt, wide);
      foreach (CORNERS[k]) send_sample(CORNERS[k]);
      for (int k = 0; k < 119; k++) begin
        if (ph == 3 && k == 10) hold_req = 1'b1;
        if (ph == 5 && k == 70) drain();
        send_sample(random_sample(fmt));
      end
    end
    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
